// ===== hw/rtl/dpf_pkg.sv =====
// Package for the debug packet framer: character codes, encoding modes,
// the job record that travels from the front end to the back end, and helpers.
// No dependencies.
package dpf_pkg;

    localparam logic [7:0] CH_START = 8'h24;  // '$'
    localparam logic [7:0] CH_HASH  = 8'h23;  // '#'
    localparam logic [7:0] CH_ESC   = 8'h7D;  // '}'
    localparam logic [7:0] CH_STAR  = 8'h2A;  // '*'
    localparam logic [7:0] ESC_XOR  = 8'h20;

    localparam logic [1:0] MODE_RAW = 2'd0;
    localparam logic [1:0] MODE_HEX = 2'd1;
    localparam logic [1:0] MODE_ESC = 2'd2;

    // Bit positions of the character steps that one job can produce.
    localparam int STEP_START = 0;
    localparam int STEP_PAY0  = 1;
    localparam int STEP_PAY1  = 2;
    localparam int STEP_HASH  = 3;
    localparam int STEP_HI    = 4;
    localparam int STEP_LO    = 5;
    localparam int NUM_STEPS  = 6;

    localparam int QUEUE_DEPTH = 2;

    typedef logic [NUM_STEPS-1:0] step_mask_t;

    typedef struct packed {
        logic       need_start;
        logic       need_pay0;
        logic       need_pay1;
        logic       need_trailer;
        logic [7:0] pay0;
        logic [7:0] pay1;
    } job_t;

    // Lowercase hex digit for one nibble.
    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] wide;
        wide = {4'h0, nib};
        if (nib < 4'd10)
        begin
            return 8'h30 + wide;
        end
        return 8'h57 + wide;
    endfunction

endpackage

// ===== hw/rtl/dpf_if.sv =====
// Handshake channels of the debug packet framer: the payload byte channel
// and the framed character channel. No dependencies.
interface dpf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       first_of_packet;
    logic       last_of_packet;

    modport source (output valid, data_byte, has_byte, first_of_packet, last_of_packet,
                    input ready);
    modport sink (input valid, data_byte, has_byte, first_of_packet, last_of_packet,
                  output ready);
endinterface

interface dpf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last_of_run;
    logic       end_of_packet;

    modport source (output valid, out_char, last_of_run, end_of_packet, input ready);
    modport sink (input valid, out_char, last_of_run, end_of_packet, output ready);
endinterface

// ===== hw/rtl/dpf_front.sv =====
// Front end of the debug packet framer: accepts payload items, tracks packet
// state and turns each item into a job of character steps. Uses dpf_pkg, dpf_in_if.
module dpf_front
(
    input  logic           clk,
    input  logic           rst_n,
    dpf_in_if.sink         item,
    input  logic [1:0]     mode,
    input  logic           queue_full,
    output logic           push,
    output dpf_pkg::job_t  job
);

    logic in_packet_reg;
    logic in_packet_next;
    logic accept;
    logic start;
    logic is_special;

    assign item.ready = !queue_full;
    assign accept     = item.valid && !queue_full;
    assign start      = item.first_of_packet || !in_packet_reg;

    assign is_special = (item.data_byte == dpf_pkg::CH_START) ||
                        (item.data_byte == dpf_pkg::CH_HASH)  ||
                        (item.data_byte == dpf_pkg::CH_ESC)   ||
                        (item.data_byte == dpf_pkg::CH_STAR);

    always_comb
    begin
        job.need_start   = start;
        job.need_pay0    = item.has_byte;
        job.need_pay1    = 1'b0;
        job.need_trailer = item.last_of_packet;
        job.pay0         = item.data_byte;
        job.pay1         = item.data_byte;
        if (mode == dpf_pkg::MODE_HEX)
        begin
            job.need_pay1 = item.has_byte;
            job.pay0      = dpf_pkg::hex_digit(item.data_byte[7:4]);
            job.pay1      = dpf_pkg::hex_digit(item.data_byte[3:0]);
        end
        else if (mode == dpf_pkg::MODE_ESC && is_special)
        begin
            job.need_pay1 = item.has_byte;
            job.pay0      = dpf_pkg::CH_ESC;
            job.pay1      = item.data_byte ^ dpf_pkg::ESC_XOR;
        end
    end

    // An idle item inside an open packet leaves nothing to send.
    assign push = accept && (start || item.has_byte || item.last_of_packet);

    always_comb
    begin
        in_packet_next = in_packet_reg;
        if (accept)
        begin
            if (item.last_of_packet)
            begin
                in_packet_next = 1'b0;
            end
            else if (start)
            begin
                in_packet_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_packet_reg <= 1'b0;
        end
        else
        begin
            in_packet_reg <= in_packet_next;
        end
    end

endmodule

// ===== hw/rtl/dpf_queue.sv =====
// Two-entry job queue between the front end and the back end of the framer.
// Uses dpf_pkg.
module dpf_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  dpf_pkg::job_t  push_job,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output dpf_pkg::job_t  head_job
);

    localparam int PTR_W = $clog2(dpf_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(dpf_pkg::QUEUE_DEPTH + 1);

    dpf_pkg::job_t entry_reg [dpf_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full       = count_reg == CNT_W'(dpf_pkg::QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_job   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(dpf_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(dpf_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ===== hw/rtl/dpf_back.sv =====
// Back end of the debug packet framer: walks the steps of the job at the
// queue head, one character per cycle unless the link stalls, keeps the
// checksum and drives the registered output channel. Uses dpf_pkg, dpf_out_if.
module dpf_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           head_valid,
    input  dpf_pkg::job_t  head_job,
    output logic           pop,
    dpf_out_if.source      link
);

    dpf_pkg::step_mask_t done_reg;
    dpf_pkg::step_mask_t done_next;
    dpf_pkg::step_mask_t need;
    dpf_pkg::step_mask_t remaining;
    dpf_pkg::step_mask_t pick;

    logic [7:0] sum_reg;
    logic [7:0] sum_next;
    logic       out_valid_reg;
    logic [7:0] out_char_reg;
    logic       last_of_run_reg;
    logic       end_of_packet_reg;

    logic       advance;
    logic       emit;
    logic       final_step;
    logic [7:0] cur_char;

    assign need = {{3{head_job.need_trailer}}, head_job.need_pay1,
                   head_job.need_pay0, head_job.need_start};
    assign remaining = head_valid ? (need & ~done_reg) : '0;
    // Isolate the lowest pending step.
    assign pick       = remaining & (~remaining + 1'b1);
    assign final_step = (remaining & ~pick) == '0;

    assign advance = !out_valid_reg || link.ready;
    assign emit    = advance && head_valid;
    assign pop     = emit && final_step;

    always_comb
    begin
        if (pick[dpf_pkg::STEP_START])
        begin
            cur_char = dpf_pkg::CH_START;
        end
        else if (pick[dpf_pkg::STEP_PAY0])
        begin
            cur_char = head_job.pay0;
        end
        else if (pick[dpf_pkg::STEP_PAY1])
        begin
            cur_char = head_job.pay1;
        end
        else if (pick[dpf_pkg::STEP_HASH])
        begin
            cur_char = dpf_pkg::CH_HASH;
        end
        else if (pick[dpf_pkg::STEP_HI])
        begin
            cur_char = dpf_pkg::hex_digit(sum_reg[7:4]);
        end
        else
        begin
            cur_char = dpf_pkg::hex_digit(sum_reg[3:0]);
        end
    end

    always_comb
    begin
        done_next = done_reg;
        sum_next  = sum_reg;
        if (emit)
        begin
            done_next = pop ? '0 : (done_reg | pick);
            if (pick[dpf_pkg::STEP_START] || pick[dpf_pkg::STEP_LO])
            begin
                sum_next = '0;
            end
            else if (pick[dpf_pkg::STEP_PAY0] || pick[dpf_pkg::STEP_PAY1])
            begin
                sum_next = sum_reg + cur_char;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg      <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
            sum_reg  <= sum_next;
            if (advance)
            begin
                out_valid_reg <= emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_char_reg      <= cur_char;
            last_of_run_reg   <= final_step;
            end_of_packet_reg <= pick[dpf_pkg::STEP_LO];
        end
    end

    assign link.valid         = out_valid_reg;
    assign link.out_char      = out_char_reg;
    assign link.last_of_run   = last_of_run_reg;
    assign link.end_of_packet = end_of_packet_reg;

endmodule

// ===== hw/rtl/debug_packet_framer.sv =====
// Top level of the debug packet framer: front end, job queue and back end.
// Uses dpf_pkg, dpf_if, dpf_front, dpf_queue, dpf_back.
//
//   Channel   Direction  Handshake           Carries
//   item      in         valid/ready         data_byte, has_byte, first/last_of_packet
//   link      out        valid/ready         out_char, last_of_run, end_of_packet
//   mode_wr   in         mode_wr_en          mode_wr_data (encoding mode)
//
// The back end sends one character per cycle while the link is ready. An item
// causes 1 character for a raw byte, 2 for a hex or escaped byte, plus
// 1 for an opening '$' and 3 for a trailer.
// Reset clears packet state, the checksum, the queue and the encoding mode.
// A two-entry job queue and the output register let the input keep
// transferring while the link stalls, until the queue fills.
module debug_packet_framer
(
    input  logic       clk,
    input  logic       rst_n,
    dpf_in_if.sink     item,
    dpf_out_if.source  link,
    input  logic       mode_wr_en,
    input  logic [1:0] mode_wr_data
);

    logic [1:0]    mode_reg;
    logic          queue_full;
    logic          push;
    logic          pop;
    logic          head_valid;
    dpf_pkg::job_t push_job;
    dpf_pkg::job_t head_job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= dpf_pkg::MODE_RAW;
        end
        else if (mode_wr_en)
        begin
            mode_reg <= mode_wr_data;
        end
    end

    dpf_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .mode       (mode_reg),
        .queue_full (queue_full),
        .push       (push),
        .job        (push_job)
    );

    dpf_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    dpf_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .link       (link)
    );

endmodule

// ===== tb/debug_packet_framer_tb.sv =====
// Testbench for debug_packet_framer: drives payload items and encoding-mode writes,
// predicts every framed character and checks the link output against it.
// Depends on dpf_pkg and the dpf_in_if / dpf_out_if interfaces.
module debug_packet_framer_tb;
    import dpf_pkg::*;

    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam int SETTLE_CYCLES = 16;
    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_ITEMS = 60;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last_of_run;
        logic       end_of_packet;
    } link_char_t;

    // Predicts the framed characters of each accepted item and checks the link.
    class frame_scoreboard;
        logic [1:0] mode;
        logic [7:0] running_sum;
        logic       in_packet;
        link_char_t expected_chars[$];
        int         mismatches;

        function new();
            mode = MODE_RAW;
            running_sum = 8'h00;
            in_packet = 1'b0;
            mismatches = 0;
        endfunction

        function logic [7:0] nibble_char(logic [3:0] nib);
            if (nib < 4'd10)
            begin
                return 8'h30 + {4'h0, nib};
            end
            return 8'h61 + {4'h0, nib} - 8'd10;
        endfunction

        function bit needs_escape(logic [7:0] b);
            return b == CH_START || b == CH_HASH || b == CH_ESC || b == CH_STAR;
        endfunction

        // Returns the number of characters the item causes.
        function int note_item(logic [7:0] b, logic has, logic first, logic last);
            link_char_t run[$];
            logic [7:0] payload[$];
            logic [7:0] sum;
            if (first || !in_packet)
            begin
                running_sum = 8'h00;
                in_packet = 1'b1;
                run.push_back('{CH_START, 1'b0, 1'b0});
            end
            if (has)
            begin
                if (mode == MODE_HEX)
                begin
                    payload.push_back(nibble_char(b[7:4]));
                    payload.push_back(nibble_char(b[3:0]));
                end
                else if (mode == MODE_ESC && needs_escape(b))
                begin
                    payload.push_back(CH_ESC);
                    payload.push_back(b ^ ESC_XOR);
                end
                else
                begin
                    payload.push_back(b);
                end
            end
            foreach (payload[i])
            begin
                running_sum = running_sum + payload[i];
                run.push_back('{payload[i], 1'b0, 1'b0});
            end
            if (last)
            begin
                sum = running_sum;
                run.push_back('{CH_HASH, 1'b0, 1'b0});
                run.push_back('{nibble_char(sum[7:4]), 1'b0, 1'b0});
                run.push_back('{nibble_char(sum[3:0]), 1'b0, 1'b1});
                running_sum = 8'h00;
                in_packet = 1'b0;
            end
            if (run.size() > 0)
            begin
                run[run.size()-1].last_of_run = 1'b1;
            end
            foreach (run[i])
            begin
                expected_chars.push_back(run[i]);
            end
            return run.size();
        endfunction

        task report(string msg);
            $display("ERROR: %s", msg);
            mismatches++;
        endtask

        task check_char(logic [7:0] c, logic lor, logic eop);
            link_char_t exp_c;
            if (expected_chars.size() == 0)
            begin
                report($sformatf("unexpected character 8'h%02h", c));
                return;
            end
            exp_c = expected_chars.pop_front();
            if (c !== exp_c.out_char)
            begin
                report($sformatf("out_char 8'h%02h, expected 8'h%02h", c, exp_c.out_char));
            end
            if (lor !== exp_c.last_of_run)
            begin
                report($sformatf("last_of_run %b, expected %b on 8'h%02h", lor,
                                 exp_c.last_of_run, exp_c.out_char));
            end
            if (eop !== exp_c.end_of_packet)
            begin
                report($sformatf("end_of_packet %b, expected %b on 8'h%02h", eop,
                                 exp_c.end_of_packet, exp_c.out_char));
            end
        endtask
    endclass

    logic       clk = 1'b0;
    logic       rst_n;
    logic       mode_wr_en;
    logic [1:0] mode_wr_data;
    bit         no_idle = 1'b0;
    int         items_sent = 0;
    int         stall_cycles = 0;

    frame_scoreboard sb = new();

    dpf_in_if  item();
    dpf_out_if link();

    debug_packet_framer i_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .link         (link),
        .mode_wr_en   (mode_wr_en),
        .mode_wr_data (mode_wr_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        link.ready <= no_idle || ($urandom_range(99) >= 32);
    end

    always @(posedge clk)
    begin
        if (rst_n && link.valid && link.ready)
        begin
            sb.check_char(link.out_char, link.last_of_run, link.end_of_packet);
        end
    end

    // Ends the run if no transfer happens on either channel for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item.valid && item.ready) || (link.valid && link.ready))
            begin
                stall_cycles = 0;
            end
            else
            begin
                stall_cycles++;
            end
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // Leaves valid high after the transfer so back-to-back items need no toggle.
    task automatic send_item(logic [7:0] b, logic has, logic first, logic last);
        int n;
        if (!no_idle && $urandom_range(99) < 32)
        begin
            item.valid <= 1'b0;
            @(posedge clk);
            while (!no_idle && $urandom_range(99) < 32)
            begin
                @(posedge clk);
            end
        end
        item.valid <= 1'b1;
        item.data_byte <= b;
        item.has_byte <= has;
        item.first_of_packet <= first;
        item.last_of_packet <= last;
        @(posedge clk);
        while (!item.ready)
        begin
            @(posedge clk);
        end
        n = sb.note_item(b, has, first, last);
        if (n > 0)
        begin
            items_sent++;
        end
    endtask

    task automatic wait_drained();
        item.valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_chars.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // The block may still be working on a char-less item, so let it settle.
    task automatic drain_and_settle();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(logic [1:0] m);
        mode_wr_en <= 1'b1;
        mode_wr_data <= m;
        @(posedge clk);
        mode_wr_en <= 1'b0;
        sb.mode = m;
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(9))
            0: return 8'h00;
            1: return 8'hFF;
            2: return CH_START;
            3: return CH_HASH;
            4: return CH_ESC;
            5: return CH_STAR;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic send_packet(int len);
        if (len == 0)
        begin
            send_item(8'($urandom_range(255)), 1'b0, 1'b1, 1'b1);
            return;
        end
        for (int i = 0; i < len; i++)
        begin
            // An idle item in the middle of a packet causes nothing.
            if (i > 0 && $urandom_range(9) == 0)
            begin
                send_item(8'($urandom_range(255)), 1'b0, 1'b0, 1'b0);
            end
            send_item(pick_byte(), 1'b1, i == 0, i == len - 1);
        end
    endtask

    task automatic run_random(int count);
        int start;
        bit paused;
        start = items_sent;
        paused = 1'b0;
        while (items_sent - start < count)
        begin
            if (!paused && items_sent - start >= count / 2)
            begin
                wait_drained();
                paused = 1'b1;
            end
            if ($urandom_range(99) < 85)
            begin
                send_packet($urandom_range(0, 5));
            end
            else
            begin
                send_item(8'($urandom_range(255)), 1'($urandom_range(1)),
                          1'($urandom_range(1)), 1'($urandom_range(1)));
            end
        end
    endtask

    logic [1:0] phase_modes[6] = '{MODE_HEX, MODE_ESC, MODE_RAW, MODE_SPARE, MODE_ESC,
                                   MODE_HEX};

    initial
    begin
        rst_n = 1'b0;
        mode_wr_en = 1'b0;
        mode_wr_data = MODE_RAW;
        item.valid = 1'b0;
        item.data_byte = 8'h00;
        item.has_byte = 1'b0;
        item.first_of_packet = 1'b0;
        item.last_of_packet = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_mode(MODE_RAW);
        send_item(8'h00, 1'b1, 1'b1, 1'b0);
        send_item(8'hFF, 1'b1, 1'b0, 1'b0);
        send_item(8'h5A, 1'b0, 1'b0, 1'b0);
        send_item(8'h41, 1'b1, 1'b0, 1'b1);
        send_item(8'h00, 1'b0, 1'b1, 1'b1);
        // Outside a packet without a first flag, then a restart inside it.
        send_item(8'h55, 1'b1, 1'b0, 1'b0);
        send_item(8'h80, 1'b1, 1'b1, 1'b0);
        send_item(8'hFF, 1'b0, 1'b0, 1'b1);
        send_item(8'h7F, 1'b1, 1'b1, 1'b1);
        drain_and_settle();

        write_mode(MODE_HEX);
        send_item(8'h00, 1'b1, 1'b1, 1'b0);
        send_item(8'hFF, 1'b1, 1'b0, 1'b0);
        send_item(8'hA5, 1'b1, 1'b0, 1'b1);
        drain_and_settle();

        write_mode(MODE_ESC);
        send_item(CH_START, 1'b1, 1'b1, 1'b0);
        send_item(CH_HASH, 1'b1, 1'b0, 1'b0);
        send_item(CH_ESC, 1'b1, 1'b0, 1'b0);
        send_item(CH_STAR, 1'b1, 1'b0, 1'b0);
        send_item(8'h5D, 1'b1, 1'b0, 1'b0);
        send_item(8'hFF, 1'b1, 1'b0, 1'b1);
        drain_and_settle();

        // The spare encoding sends bytes raw.
        write_mode(MODE_SPARE);
        send_item(CH_START, 1'b1, 1'b1, 1'b0);
        send_item(CH_ESC, 1'b1, 1'b0, 1'b1);
        drain_and_settle();

        foreach (phase_modes[p])
        begin
            write_mode(phase_modes[p]);
            no_idle = (p == 4);
            run_random(PHASE_ITEMS);
            drain_and_settle();
        end
        no_idle = 1'b0;

        if (sb.mismatches == 0 && sb.expected_chars.size() == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
hw/rtl/dpf_pkg.sv
hw/rtl/dpf_if.sv
hw/rtl/dpf_front.sv
hw/rtl/dpf_queue.sv
hw/rtl/dpf_back.sv
hw/rtl/debug_packet_framer.sv
tb/debug_packet_framer_tb.sv
